// ===== design/gspd_pkg.sv =====
package gspd_pkg;

  localparam int unsigned CAL_SAMPLES = 500;
  localparam int unsigned LOOP_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [LOOP_W-1:0] CAL_LIMIT = LOOP_W'(CAL_SAMPLES);

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned AXIS_W = 2;

  typedef logic [4:0] step_t;
  typedef logic [AXIS_W-1:0] axis_t;

  // loop steps that do something other than send a dummy byte
  localparam step_t STEP_ID      = 5'd1;
  localparam step_t STEP_CTRL2_D = 5'd2;
  localparam step_t STEP_CTRL3_A = 5'd3;
  localparam step_t STEP_CTRL3_D = 5'd4;
  localparam step_t STEP_INT_A   = 5'd5;
  localparam step_t STEP_INT_D   = 5'd6;
  localparam step_t STEP_CTRL1_A = 5'd7;
  localparam step_t STEP_CTRL1_D = 5'd8;
  localparam step_t STEP_TEMP_A  = 5'd9;
  localparam step_t STEP_TEMP    = 5'd11;
  localparam step_t STEP_XL_A    = 5'd13;
  localparam step_t STEP_X_LO    = 5'd15;
  localparam step_t STEP_X_HI    = 5'd17;
  localparam step_t STEP_Y_LO    = 5'd19;
  localparam step_t STEP_Y_HI    = 5'd21;
  localparam step_t STEP_Z_LO    = 5'd23;
  localparam step_t STEP_Z_HI    = 5'd25;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam logic [7:0] RD_FLAG    = 8'h80;
  localparam logic [7:0] DUMMY      = 8'hFF;
  localparam logic [7:0] A_WHOAMI   = 8'h0F;
  localparam logic [7:0] A_CTRL1    = 8'h20;
  localparam logic [7:0] A_CTRL2    = 8'h21;
  localparam logic [7:0] A_CTRL3    = 8'h22;
  localparam logic [7:0] A_TEMP     = 8'h26;
  localparam logic [7:0] A_STATUS   = 8'h27;
  localparam logic [7:0] A_OUT_X_L  = 8'h28;
  localparam logic [7:0] A_OUT_X_H  = 8'h29;
  localparam logic [7:0] A_OUT_Y_L  = 8'h2A;
  localparam logic [7:0] A_OUT_Y_H  = 8'h2B;
  localparam logic [7:0] A_OUT_Z_L  = 8'h2C;
  localparam logic [7:0] A_OUT_Z_H  = 8'h2D;
  localparam logic [7:0] A_INT1_CFG = 8'h30;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CTRL1   = 2'd0;
  localparam cfg_idx_t CFG_CTRL2   = 2'd1;
  localparam cfg_idx_t CFG_CTRL3   = 2'd2;
  localparam cfg_idx_t CFG_INT_CFG = 2'd3;

  localparam logic [7:0] CTRL1_RST   = 8'd255;
  localparam logic [7:0] CTRL2_RST   = 8'd41;
  localparam logic [7:0] CTRL3_RST   = 8'd56;
  localparam logic [7:0] INT_CFG_RST = 8'd42;

endpackage

// ===== design/gyro_spi_poll_deadband.sv =====
// SPI byte poller for a three-axis gyro with a min/max deadband. Each rx byte
// accepted on the in_ channel yields exactly one result on the out_ channel:
// the next byte to transmit plus the sensor readings it completed. A 26-byte
// loop reads the identity register, writes the four control bytes from the
// cfg_ registers, reads temperature and status, then X, Y and Z rates. For the
// first CAL_SAMPLES loops the corrected rate is zero while per-axis min/max
// are tracked; afterwards rates inside [min, max] read as zero. One byte is
// taken per clock: the decode, one 16-bit compare pair and the min/max update
// sit between the input port and a single output register, and a new byte is
// taken whenever that register is empty or being drained in the same cycle.
// Control registers may be rewritten only while idle.
module gyro_spi_poll_deadband
  import gspd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_new_transaction,
  output logic               out_sample_valid,
  output logic [1:0]         out_sample_axis,
  output logic signed [15:0] out_raw_rate,
  output logic signed [15:0] out_corrected_rate,
  output logic               out_calibrating,
  output logic [7:0]         out_device_id,
  output logic signed [7:0]  out_temperature,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0] ctrl1_r, ctrl2_r, ctrl3_r, int_cfg_r;

  step_t             step_r, step_nxt;
  logic [7:0]        low_hold_r, low_hold_nxt;
  logic [7:0]        id_hold_r, id_hold_nxt;
  logic [7:0]        temp_hold_r, temp_hold_nxt;
  logic [LOOP_W-1:0] loop_cnt_r, loop_cnt_nxt;
  logic signed [15:0] axis_min_r [NUM_AXES];
  logic signed [15:0] axis_max_r [NUM_AXES];

  logic              out_valid_r;
  logic [7:0]        tx_r;
  logic              newt_r, svalid_r, calib_r;
  axis_t             axis_r;
  logic signed [15:0] raw_r, corr_r;
  logic [7:0]        id_out_r, temp_out_r;

  logic              accept;
  logic [7:0]        tx_c;
  logic              newt_c, svalid_c, calib_c, in_cal;
  axis_t             axis_c;
  logic signed [15:0] raw_c, corr_c, cur_min, cur_max;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r   <= CTRL1_RST;
      ctrl2_r   <= CTRL2_RST;
      ctrl3_r   <= CTRL3_RST;
      int_cfg_r <= INT_CFG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CTRL1:   ctrl1_r   <= cfg_wdata;
        CFG_CTRL2:   ctrl2_r   <= cfg_wdata;
        CFG_CTRL3:   ctrl3_r   <= cfg_wdata;
        CFG_INT_CFG: int_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_cal  = loop_cnt_r < CAL_LIMIT;
  assign raw_c   = signed'({in_rx_byte, low_hold_r});
  assign cur_min = axis_min_r[axis_c];
  assign cur_max = axis_max_r[axis_c];

  always_comb begin
    tx_c          = DUMMY;
    newt_c        = 1'b0;
    svalid_c      = 1'b0;
    axis_c        = AXIS_X;
    low_hold_nxt  = low_hold_r;
    id_hold_nxt   = id_hold_r;
    temp_hold_nxt = temp_hold_r;
    loop_cnt_nxt  = loop_cnt_r;
    unique case (step_r)
      STEP_ID: begin
        id_hold_nxt = in_rx_byte;
        tx_c        = A_CTRL2;
        newt_c      = 1'b1;
      end
      STEP_CTRL2_D: tx_c = ctrl2_r;
      STEP_CTRL3_A: begin
        tx_c   = A_CTRL3;
        newt_c = 1'b1;
      end
      STEP_CTRL3_D: tx_c = ctrl3_r;
      STEP_INT_A: begin
        tx_c   = A_INT1_CFG;
        newt_c = 1'b1;
      end
      STEP_INT_D: tx_c = int_cfg_r;
      STEP_CTRL1_A: begin
        tx_c   = A_CTRL1;
        newt_c = 1'b1;
      end
      STEP_CTRL1_D: tx_c = ctrl1_r;
      STEP_TEMP_A: begin
        tx_c   = A_TEMP | RD_FLAG;
        newt_c = 1'b1;
      end
      STEP_TEMP: begin
        temp_hold_nxt = in_rx_byte;
        tx_c          = A_STATUS | RD_FLAG;
        newt_c        = 1'b1;
      end
      STEP_XL_A: begin
        tx_c   = A_OUT_X_L | RD_FLAG;
        newt_c = 1'b1;
      end
      STEP_X_LO: begin
        low_hold_nxt = in_rx_byte;
        tx_c         = A_OUT_X_H | RD_FLAG;
        newt_c       = 1'b1;
      end
      STEP_Y_LO: begin
        low_hold_nxt = in_rx_byte;
        tx_c         = A_OUT_Y_H | RD_FLAG;
        newt_c       = 1'b1;
      end
      STEP_Z_LO: begin
        low_hold_nxt = in_rx_byte;
        tx_c         = A_OUT_Z_H | RD_FLAG;
        newt_c       = 1'b1;
      end
      STEP_X_HI: begin
        axis_c   = AXIS_X;
        svalid_c = 1'b1;
        tx_c     = A_OUT_Y_L | RD_FLAG;
        newt_c   = 1'b1;
      end
      STEP_Y_HI: begin
        axis_c   = AXIS_Y;
        svalid_c = 1'b1;
        tx_c     = A_OUT_Z_L | RD_FLAG;
        newt_c   = 1'b1;
      end
      STEP_Z_HI: begin
        axis_c   = AXIS_Z;
        svalid_c = 1'b1;
        tx_c     = A_WHOAMI | RD_FLAG;
        newt_c   = 1'b1;
        if (in_cal) loop_cnt_nxt = loop_cnt_r + LOOP_W'(1);
      end
      default: ;
    endcase
    step_nxt = (step_r == STEP_Z_HI) ? '0 : step_r + step_t'(1);
  end

  // deadband: pass only values outside the band learned during calibration
  always_comb begin
    corr_c = '0;
    if (svalid_c && !in_cal && (raw_c < cur_min || raw_c > cur_max)) corr_c = raw_c;
  end

  assign calib_c = loop_cnt_nxt < CAL_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      low_hold_r  <= '0;
      id_hold_r   <= '0;
      temp_hold_r <= '0;
      loop_cnt_r  <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_min_r[i] <= '0;
        axis_max_r[i] <= '0;
      end
    end else if (accept) begin
      step_r      <= step_nxt;
      low_hold_r  <= low_hold_nxt;
      id_hold_r   <= id_hold_nxt;
      temp_hold_r <= temp_hold_nxt;
      loop_cnt_r  <= loop_cnt_nxt;
      if (svalid_c && in_cal) begin
        if (raw_c > cur_max) axis_max_r[axis_c] <= raw_c;
        if (raw_c < cur_min) axis_min_r[axis_c] <= raw_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_r       <= tx_c;
      newt_r     <= newt_c;
      svalid_r   <= svalid_c;
      axis_r     <= svalid_c ? axis_c : AXIS_X;
      raw_r      <= svalid_c ? raw_c : '0;
      corr_r     <= corr_c;
      calib_r    <= calib_c;
      id_out_r   <= id_hold_nxt;
      temp_out_r <= temp_hold_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_byte         = tx_r;
  assign out_new_transaction = newt_r;
  assign out_sample_valid    = svalid_r;
  assign out_sample_axis     = axis_r;
  assign out_raw_rate        = raw_r;
  assign out_corrected_rate  = corr_r;
  assign out_calibrating     = calib_r;
  assign out_device_id       = id_out_r;
  assign out_temperature     = signed'(temp_out_r);

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_Z_HI)
    else $error("loop step left the 26-step schedule");

  a_sample_newt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && svalid_r |-> newt_r)
    else $error("completed sample without a new transaction");

  a_corr_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && corr_r != '0 |-> corr_r == raw_r && !calib_r && svalid_r)
    else $error("corrected rate differs from raw rate outside calibration");

  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    axis_min_r[0] <= axis_max_r[0] && axis_min_r[1] <= axis_max_r[1] &&
    axis_min_r[2] <= axis_max_r[2])
    else $error("deadband minimum above maximum");

  a_loop_sat: assert property (@(posedge clk) disable iff (!rst_n)
    loop_cnt_r <= CAL_LIMIT)
    else $error("calibration loop count passed its limit");
`endif

endmodule
